// ===== design/bltb_pkg.sv =====
// Package for the byte-level text-to-bytes decoder.
// Holds the request/response types, hold codes and the reverse byte map.
// No dependencies.
package bltb_pkg;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [7:0] raw_byte;
      logic       run_last;
      logic       stream_end;
   } rsp_type;

   // number of pending bytes in the hold
   localparam logic [1:0] HOLD_NONE = 2'd0;
   localparam logic [1:0] HOLD_ONE  = 2'd1;
   localparam logic [1:0] HOLD_TWO  = 2'd2;

   // extra bytes a lead byte asks for
   localparam logic [1:0] EXTRA_NONE = 2'd0;
   localparam logic [1:0] EXTRA_ONE  = 2'd1;
   localparam logic [1:0] EXTRA_TWO  = 2'd2;

   // decoder outputs toward the top level
   typedef struct packed {
      logic [1:0] num;       // results produced: 0, 1 or 2
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [1:0] count_in;  // next hold count
      logic       hold0_we;
      logic       hold1_we;
   } dec_type;

   function automatic logic [1:0] lead_extra(input logic [7:0] c);
      logic [1:0] r;
      r = EXTRA_NONE;
      if ((c & 8'hE0) == 8'hC0) r = EXTRA_ONE;
      else if ((c & 8'hF0) == 8'hE0) r = EXTRA_TWO;
      return r;
   endfunction

   function automatic logic [7:0] reverse_map(input logic [15:0] cp);
      logic [6:0] n;
      logic [7:0] r;
      n = 7'(cp - 16'd256);
      if (cp < 16'd256) begin
         if (cp[7:0] inside {[8'd33:8'd126], [8'd161:8'd172], [8'd174:8'd255]}) begin
            r = cp[7:0];
         end else begin
            r = 8'd0;
         end
      end else if (cp <= 16'd323) begin
         if (n < 7'd33) r = {1'b0, n};
         else if (n < 7'd67) r = {1'b0, n} + 8'd94;
         else r = 8'd173;
      end else begin
         r = cp[7:0];
      end
      return r;
   endfunction

endpackage

// ===== design/byte_level_text_to_bytes_decoder_unit.sv =====
// Byte-level text-to-bytes decoder, top level.
// A completing request shows its first response in the cycle after acceptance.
// Throughput: one request per cycle while the receiver is ready; a request with two
// responses stalls the input while the second drains from the two-slot result register.
// Reset (synchronous, active high) empties the hold and the result register;
// held bytes are not cleared.
module byte_level_text_to_bytes_decoder_unit
   import bltb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // hold state: count of pending bytes and the bytes themselves
   logic [1:0] held_count_ff, held_count_in;
   logic [7:0] held0_ff, held1_ff;

   dec_type dec;
   logic    accept;
   rsp_type res0, res1;

   assign accept = req_valid && req_ready;

   bltb_decode u_decode (
      .text_byte  (req_data.text_byte),
      .is_last    (req_data.is_last),
      .held_count (held_count_ff),
      .held0      (held0_ff),
      .held1      (held1_ff),
      .dec        (dec)
   );

   // run_last marks the final response of this request,
   // stream_end that response when the request closes the stream
   always_comb begin
      res0.raw_byte   = dec.byte0;
      res0.run_last   = (dec.num == 2'd1);
      res0.stream_end = (dec.num == 2'd1) && req_data.is_last;
      res1.raw_byte   = dec.byte1;
      res1.run_last   = 1'b1;
      res1.stream_end = req_data.is_last;
   end

   bltb_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_num  (dec.num),
      .push0     (res0),
      .push1     (res1),
      .can_push  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign held_count_in = accept ? dec.count_in : held_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= HOLD_NONE;
      end else begin
         held_count_ff <= held_count_in;
      end
   end

   // pending lead and continuation bytes, written only when captured
   always_ff @(posedge clock) begin
      if (accept && dec.hold0_we) begin
         held0_ff <= req_data.text_byte;
      end
      if (accept && dec.hold1_we) begin
         held1_ff <= req_data.text_byte;
      end
   end

endmodule

// ===== design/bltb_decode.sv =====
// UTF-8 sequence decode and reverse byte map for one request.
// Depends on bltb_pkg.
module bltb_decode
   import bltb_pkg::*;
(
   input  logic [7:0] text_byte,
   input  logic       is_last,
   input  logic [1:0] held_count,
   input  logic [7:0] held0,
   input  logic [7:0] held1,
   output dec_type    dec
);

   always_comb begin
      dec = '0;
      dec.count_in = HOLD_NONE;
      case (held_count)
         HOLD_ONE: begin
            if (lead_extra(held0) == EXTRA_ONE) begin
               dec.num   = 2'd1;
               dec.byte0 = reverse_map({5'd0, held0[4:0], text_byte[5:0]});
            end else if (is_last) begin
               // truncated three-byte lead: lead and byte taken raw
               dec.num   = 2'd2;
               dec.byte0 = reverse_map({8'd0, held0});
               dec.byte1 = reverse_map({8'd0, text_byte});
            end else begin
               dec.hold1_we = 1'b1;
               dec.count_in = HOLD_TWO;
            end
         end
         HOLD_TWO: begin
            dec.num   = 2'd1;
            dec.byte0 = reverse_map({held0[3:0], held1[5:0], text_byte[5:0]});
         end
         default: begin
            if (lead_extra(text_byte) == EXTRA_NONE || is_last) begin
               dec.num   = 2'd1;
               dec.byte0 = reverse_map({8'd0, text_byte});
            end else begin
               dec.hold0_we = 1'b1;
               dec.count_in = HOLD_ONE;
            end
         end
      endcase
   end

endmodule

// ===== design/bltb_out_queue.sv =====
// Two-slot result register for the decoder; loads up to two responses at once.
// Depends on bltb_pkg.
module bltb_out_queue
   import bltb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  logic [1:0] push_num,
   input  rsp_type push0,
   input  rsp_type push1,
   output logic    can_push,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic [1:0] count_ff, count_in;
   rsp_type    slot0_ff, slot0_in;
   rsp_type    slot1_ff, slot1_in;
   logic       pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = slot0_ff;
   // room for two results once the head leaves
   assign can_push  = (count_ff == 2'd0) || (count_ff == 2'd1 && rsp_ready);

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (push) begin
         count_in = push_num;
         slot0_in = push0;
         slot1_in = push1;
      end else if (pop) begin
         count_in = count_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

// ===== tb/tb.sv =====
// Testbench for byte_level_text_to_bytes_decoder_unit: directed and random UTF-8 byte streams,
// checked result by result against an in-bench decoder and reverse byte map.
// Depends on bltb_pkg (request/response types, hold and lead codes) and the unit itself.
module tb
   import bltb_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // generous ceiling on the length of the whole run
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned PRINT_LIMIT = 100;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   byte_level_text_to_bytes_decoder_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Knobs shared by the test tasks and the background processes
   // ---------------------------------------------------------------------
   int unsigned tx_idle_pct   = 0;   // chance per cycle that the sender sits idle
   int unsigned rx_stall_pct  = 0;   // chance per cycle that the receiver stalls
   int unsigned rx_hold_left  = 0;   // forced receiver hold-off, counted down below
   int unsigned requests_sent = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count   = 0;

   // ---------------------------------------------------------------------
   // Decoder model: pending lead/continuation bytes and their count,
   // plus the queue of raw bytes still owed by the unit.
   // ---------------------------------------------------------------------
   logic [7:0] pend_bytes [2];
   logic [1:0] pend_count = HOLD_NONE;
   rsp_type    expected_bytes [$];

   // how many continuation bytes a lead byte asks for; only the lead pattern counts
   function automatic logic [1:0] lead_kind(input logic [7:0] c);
      if (c[7:5] == 3'b110) return EXTRA_ONE;
      if (c[7:4] == 4'b1110) return EXTRA_TWO;
      return EXTRA_NONE;
   endfunction

   // code point back to the original byte
   function automatic logic [7:0] unmap_code_point(input logic [15:0] cp);
      int unsigned v;
      int unsigned idx;
      v = 32'(cp);
      if (v < 256) begin
         // printable bytes stand for themselves; the rest never appear directly
         if ((v >= 33 && v <= 126) || (v >= 161 && v <= 255 && v != 173)) return cp[7:0];
         return 8'd0;
      end else if (v <= 323) begin
         // 256 + n is the n-th unprintable byte: 0..32, 127..160, then 173
         idx = v - 256;
         if (idx < 33) return 8'(idx);
         if (idx < 67) return 8'(idx + 94);
         return 8'd173;
      end
      return cp[7:0];
   endfunction

   // advance the model by one accepted request and queue what it owes
   task automatic predict_request(input req_type r);
      logic [15:0] cps [2];
      int          n;
      rsp_type     o;
      n = 0;
      case (pend_count)
         HOLD_ONE: begin
            if (lead_kind(pend_bytes[0]) == EXTRA_ONE) begin
               cps[0] = {5'd0, pend_bytes[0][4:0], r.text_byte[5:0]};
               n = 1;
               pend_count = HOLD_NONE;
            end else if (r.is_last) begin
               // three-byte lead cut short by the end of the stream: both go out raw
               cps[0] = {8'd0, pend_bytes[0]};
               cps[1] = {8'd0, r.text_byte};
               n = 2;
               pend_count = HOLD_NONE;
            end else begin
               pend_bytes[1] = r.text_byte;
               pend_count = HOLD_TWO;
            end
         end
         HOLD_TWO: begin
            cps[0] = {pend_bytes[0][3:0], pend_bytes[1][5:0], r.text_byte[5:0]};
            n = 1;
            pend_count = HOLD_NONE;
         end
         default: begin
            pend_count = HOLD_NONE;
            if (lead_kind(r.text_byte) == EXTRA_NONE || r.is_last) begin
               cps[0] = {8'd0, r.text_byte};
               n = 1;
            end else begin
               pend_bytes[0] = r.text_byte;
               pend_count = HOLD_ONE;
            end
         end
      endcase
      for (int k = 0; k < n; k++) begin
         o.raw_byte   = unmap_code_point(cps[k]);
         o.run_last   = (k == n - 1);
         o.stream_end = (k == n - 1) && r.is_last;
         expected_bytes.push_back(o);
      end
   endtask

   // one line per mismatch, capped so a broken unit cannot flood the log
   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------
   // Response side: random ready with an optional long hold-off.
   // Values seen right after the edge are the ones the handshake used,
   // since every driver here updates through nonblocking assignments.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (rx_hold_left > 0) begin
         rsp_ready <= 1'b0;
         rx_hold_left = rx_hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("response with nothing owed: raw=%h run_last=%b end=%b",
                                      rsp_data.raw_byte, rsp_data.run_last, rsp_data.stream_end));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_data.raw_byte !== want.raw_byte)
               report_mismatch($sformatf("raw_byte %h, expected %h",
                                         rsp_data.raw_byte, want.raw_byte));
            if (rsp_data.run_last !== want.run_last)
               report_mismatch($sformatf("run_last %b, expected %b (raw %h)",
                                         rsp_data.run_last, want.run_last, want.raw_byte));
            if (rsp_data.stream_end !== want.stream_end)
               report_mismatch($sformatf("stream_end %b, expected %b (raw %h)",
                                         rsp_data.stream_end, want.stream_end, want.raw_byte));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Offer one request and wait for it to be taken. Valid stays high on
   // return so back-to-back requests need no drop; the next call or
   // wait_for_drain decides whether it goes low.
   task automatic send_byte(input logic [7:0] b, input logic last);
      req_type r;
      r.text_byte = b;
      r.is_last   = last;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_request(r);
      requests_sent++;
   endtask

   // sender goes quiet until every owed response is back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] cont_byte();
      // mostly proper 10xxxxxx, sometimes arbitrary top bits
      if ($urandom_range(99) < 85) return {2'b10, 6'($urandom_range(63))};
      return 8'($urandom_range(255));
   endfunction

   // one character, now and then a stray byte; when fin is set it closes the stream,
   // occasionally cut short to hit the truncated-lead paths
   task automatic send_char(input logic fin);
      int unsigned pick;
      logic [7:0]  lead;
      pick = $urandom_range(99);
      if (pick < 35) begin
         send_byte(8'($urandom_range(127)), fin);
      end else if (pick < 45) begin
         // stray continuation or 1111xxxx: each stands alone
         if ($urandom_range(1)) send_byte({2'b10, 6'($urandom_range(63))}, fin);
         else send_byte({4'b1111, 4'($urandom_range(15))}, fin);
      end else if (pick < 75) begin
         // two-byte; C4 leads land in the 256..323 remap window, C5 leads straddle its top
         if ($urandom_range(99) < 25) lead = $urandom_range(1) ? 8'hC4 : 8'hC5;
         else lead = {3'b110, 5'($urandom_range(31))};
         if (fin && $urandom_range(99) < 15) begin
            send_byte(lead, 1'b1);
         end else begin
            send_byte(lead, 1'b0);
            send_byte(cont_byte(), fin);
         end
      end else begin
         lead = {4'b1110, 4'($urandom_range(15))};
         pick = $urandom_range(99);
         if (fin && pick < 10) begin
            send_byte(lead, 1'b1);
         end else if (fin && pick < 30) begin
            send_byte(lead, 1'b0);
            send_byte(cont_byte(), 1'b1);
         end else begin
            send_byte(lead, 1'b0);
            send_byte(cont_byte(), 1'b0);
            send_byte(cont_byte(), fin);
         end
      end
   endtask

   // a short stream of characters, or now and then plain noise
   task automatic send_stream();
      int unsigned n;
      n = $urandom_range(12, 1);
      if ($urandom_range(99) < 10) begin
         for (int unsigned i = 0; i < n; i++)
            send_byte(8'($urandom_range(255)), ($urandom_range(7) == 0) || (i == n - 1));
      end else begin
         for (int unsigned i = 0; i < n; i++) send_char(i == n - 1);
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // extremes, every lead pattern, remap window edges, truncation at end
   task automatic test_directed_cases();
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      send_byte(8'h00, 1'b0);   // zero byte
      send_byte(8'h20, 1'b0);   // unprintable space
      send_byte(8'h41, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hFF, 1'b0);   // 1111xxxx alone
      send_byte(8'h80, 1'b0);   // stray continuation
      send_byte(8'hAD, 1'b0);   // soft hyphen, unprintable
      send_byte(8'hC4, 1'b0);   // U+0100 -> byte 0
      send_byte(8'h80, 1'b0);
      send_byte(8'hC5, 1'b0);   // U+0143 -> byte 173, top of the window
      send_byte(8'h83, 1'b0);
      send_byte(8'hC4, 1'b0);   // U+0121 -> byte 127
      send_byte(8'hA1, 1'b0);
      send_byte(8'hEF, 1'b0);   // U+FFFF
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hE0, 1'b0);   // continuation top bits ignored
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hDF, 1'b0);   // two-byte closing the stream
      send_byte(8'hFF, 1'b1);
      send_byte(8'hC3, 1'b1);   // lead with nothing after it
      send_byte(8'hE2, 1'b0);   // three-byte lead, only the last byte follows
      send_byte(8'h82, 1'b1);
      send_byte(8'hE9, 1'b1);
      wait_for_drain();
   endtask

   task automatic test_random_streams(input int unsigned n_requests,
                                      input int unsigned idle_pct,
                                      input int unsigned stall_pct);
      int unsigned stop_at;
      tx_idle_pct  = idle_pct;
      rx_stall_pct = stall_pct;
      stop_at = requests_sent + n_requests;
      while (requests_sent < stop_at) send_stream();
      wait_for_drain();
   endtask

   // receiver frozen while the sender keeps pushing: output register
   // fills and the unit has to hold its input off
   task automatic test_output_backpressure();
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      rx_hold_left = 300;
      for (int i = 0; i < 15; i++) send_stream();
      wait_for_drain();
   endtask

   // sender stops mid-run and waits for everything owed before resuming
   task automatic test_pause_until_drained();
      tx_idle_pct  = 20;
      rx_stall_pct = 20;
      for (int i = 0; i < 6; i++) begin
         send_stream();
         wait_for_drain();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_streams(350, 0, 0);
      test_random_streams(350, 64, 0);
      test_random_streams(350, 0, 64);
      test_random_streams(350, 27, 27);
      test_output_backpressure();
      test_pause_until_drained();

      wait_for_drain();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
